// ===== design/c_escape_sequence_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape sequence decoder
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CESD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CESD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CESD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CESD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/cesd_pkg.sv =====
// ----------------------------------------------------------------------------
// cesd_pkg
// Types, constants and helper functions shared by the escape sequence decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_OCT    = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_HEX1   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
    } t_result;

    // results of one transaction, in delivery order
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_dec_out;

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    // {is_hex, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic ok;
        logic [3:0] nib;
        ok  = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h66)) ||
              ((b >= 8'h41) && (b <= 8'h46));
        nib = (b > 8'h39) ? (b[3:0] + 4'd9) : b[3:0];
        return {ok, nib};
    endfunction

    // {known, value} for single-character escapes
    function automatic logic [8:0] esc_char(input logic [7:0] b);
        logic [8:0] r;
        unique case (b)
            8'h61:   r = {1'b1, 8'h07};  // a
            8'h62:   r = {1'b1, 8'h08};  // b
            8'h66:   r = {1'b1, 8'h0c};  // f
            8'h6e:   r = {1'b1, 8'h0a};  // n
            8'h72:   r = {1'b1, 8'h0d};  // r
            8'h74:   r = {1'b1, 8'h09};  // t
            8'h76:   r = {1'b1, 8'h0b};  // v
            8'h5c, 8'h3f, 8'h27, 8'h22: r = {1'b1, b};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

    function automatic logic is_hex_intro(input logic [7:0] b);
        return (b == 8'h78) || (b == 8'h58);
    endfunction

endpackage

// ===== design/cesd_in_reg.sv =====
// ----------------------------------------------------------------------------
// cesd_in_reg
// Input register: holds one source byte until the decoder can take it.
// ----------------------------------------------------------------------------
module cesd_in_reg
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_room,
    output logic       o_consume,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       accept;

    assign o_consume = r_valid && i_room;
    assign o_ready   = !r_valid || o_consume;
    assign accept    = i_valid && o_ready;
    assign n_valid   = accept || (r_valid && !o_consume);
    assign o_byte    = r_byte;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

endmodule

// ===== design/cesd_decode.sv =====
// ----------------------------------------------------------------------------
// cesd_decode
// Parser state and the single-pass decode of one source byte into up to two
// results.
// ----------------------------------------------------------------------------
`include "c_escape_sequence_decoder_assert.svh"

module cesd_decode
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_consume,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_dec_out   o_dec
);

    t_mode      r_mode,    n_mode;
    logic [7:0] r_pend,    n_pend;
    logic [1:0] r_dcnt,    n_dcnt;
    logic       r_halted,  n_halted;

    logic       a_en, b_en, c_en, plain_go;
    logic [7:0] a_val, b_val, c_val, oct_val;
    logic [1:0] dcnt_inc, cnt;
    logic [4:0] hx;
    logic [8:0] esc;
    t_result    res0, res1;

    assign hx       = hex_digit(i_byte);
    assign esc      = esc_char(i_byte);
    assign oct_val  = {r_pend[4:0], i_byte[2:0]};
    assign dcnt_inc = r_dcnt + 2'd1;

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_dcnt   = r_dcnt;
        n_halted = r_halted;
        a_en     = 1'b0;
        a_val    = r_pend;
        plain_go = 1'b0;
        b_en     = 1'b0;
        b_val    = i_byte;

        unique case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                if (i_byte == CH_NUL) begin
                    n_halted = 1'b1;
                end else if (is_octal(i_byte)) begin
                    n_pend = {5'd0, i_byte[2:0]};
                    n_dcnt = 2'd1;
                    n_mode = MODE_OCT;
                end else if (esc[8]) begin
                    a_en  = 1'b1;
                    a_val = esc[7:0];
                end else if (is_hex_intro(i_byte)) begin
                    n_mode = MODE_HEX;
                end
            end
            MODE_OCT: begin
                if (is_octal(i_byte)) begin
                    n_pend = oct_val;
                    n_dcnt = dcnt_inc;
                    if (dcnt_inc == 2'd3) begin
                        a_en   = 1'b1;
                        a_val  = oct_val;
                        n_mode = MODE_NORMAL;
                        n_dcnt = 2'd0;
                    end
                end else begin
                    a_en     = 1'b1;
                    n_mode   = MODE_NORMAL;
                    n_dcnt   = 2'd0;
                    plain_go = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hx[4]) begin
                    n_pend = {4'd0, hx[3:0]};
                    n_mode = MODE_HEX1;
                end else begin
                    n_mode   = MODE_NORMAL;
                    plain_go = 1'b1;
                end
            end
            MODE_HEX1: begin
                n_mode = MODE_NORMAL;
                a_en   = 1'b1;
                if (hx[4]) begin
                    a_val = {r_pend[3:0], hx[3:0]};
                end else begin
                    plain_go = 1'b1;
                end
            end
            default: begin
                n_mode   = MODE_NORMAL;
                plain_go = 1'b1;
            end
        endcase

        if (plain_go) begin
            priority if (i_byte == CH_NUL) begin
                n_halted = 1'b1;
                n_mode   = MODE_NORMAL;
            end else if (i_byte == CH_BACKSLASH) begin
                n_mode = MODE_ESC;
            end else begin
                b_en = 1'b1;
            end
        end

        // a value still being built is flushed at end of string
        c_en  = i_last && ((n_mode == MODE_OCT) || (n_mode == MODE_HEX1));
        c_val = n_pend;

        if (r_halted) begin
            a_en   = 1'b0;
            b_en   = 1'b0;
            c_en   = 1'b0;
            n_mode = r_mode;
            n_pend = r_pend;
            n_dcnt = r_dcnt;
        end

        cnt  = {1'b0, a_en} + {1'b0, b_en} + {1'b0, c_en};
        res0 = a_en ? t_result'{data: a_val, byte_valid: 1'b1, last: 1'b0} :
               b_en ? t_result'{data: b_val, byte_valid: 1'b1, last: 1'b0} :
                      t_result'{data: c_val, byte_valid: 1'b1, last: 1'b0};
        res1 = (a_en && b_en) ? t_result'{data: b_val, byte_valid: 1'b1, last: 1'b0} :
                                t_result'{data: c_val, byte_valid: 1'b1, last: 1'b0};

        if (i_last) begin
            if (cnt == 2'd0) begin
                res0 = t_result'{data: 8'h00, byte_valid: 1'b0, last: 1'b0};
                cnt  = 2'd1;
            end
            if (cnt == 2'd1) begin
                res0.last = 1'b1;
            end else begin
                res1.last = 1'b1;
            end
            n_mode   = MODE_NORMAL;
            n_pend   = 8'h00;
            n_dcnt   = 2'd0;
            n_halted = 1'b0;
        end
    end

    always_comb begin
        o_dec.cnt = i_consume ? cnt : 2'd0;
        o_dec.r0  = res0;
        o_dec.r1  = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_pend   <= 8'h00;
            r_dcnt   <= 2'd0;
            r_halted <= 1'b0;
        end else if (i_consume) begin
            r_mode   <= n_mode;
            r_pend   <= n_pend;
            r_dcnt   <= n_dcnt;
            r_halted <= n_halted;
        end
    end

    `CESD_ASSERT_IMPLY(a_halted_silent, i_consume && r_halted && !i_last, o_dec.cnt == 2'd0, "halted decoder produced a byte")
    `CESD_ASSERT_NEXT(a_last_clears, i_consume && i_last, (r_mode == MODE_NORMAL) && !r_halted && (r_dcnt == 2'd0), "state not cleared after end of string")
    `CESD_ASSERT_IMPLY(a_last_emits, i_consume && i_last, o_dec.cnt != 2'd0, "end of string produced no result")

endmodule

// ===== design/cesd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cesd_out_fifo
// Small result queue: takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
`include "c_escape_sequence_decoder_assert.svh"

module cesd_out_fifo
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dec_out   i_push,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_byte_valid,
    output logic       o_last
);

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [PTR_W-1:0]   wr_ptr1;
    logic               pop;

    assign o_valid      = (r_count != '0);
    assign pop          = o_valid && i_ready;
    assign o_room       = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_byte       = r_mem[r_rd_ptr].data;
    assign o_byte_valid = r_mem[r_rd_ptr].byte_valid;
    assign o_last       = r_mem[r_rd_ptr].last;

    assign wr_ptr1  = r_wr_ptr + PTR_W'(1);
    assign n_wr_ptr = r_wr_ptr + PTR_W'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(pop);
    assign n_count  = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    `CESD_ASSERT_IMPLY(a_push_has_room, i_push.cnt != 2'd0, r_count <= CNT_W'(FIFO_DEPTH - 2), "result queue overflow")
    `CESD_ASSERT_IMPLY(a_push_cnt_max, 1'b1, i_push.cnt != 2'd3, "more than two results in one transaction")
    `CESD_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= CNT_W'(FIFO_DEPTH), "result count above queue depth")

endmodule

// ===== design/c_escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Decodes C string literal escapes from a byte stream into decoded bytes.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle and decodes it in a single pass between the
// input register and a four-entry result queue; the results are written into the
// queue and presented on the output from there. Most bytes yield zero or
// one result. A byte that closes an octal or hex value and also yields its own
// result produces two, but such a byte is always preceded by at least two
// bytes that yield nothing (a backslash and a digit), so with a ready sink the
// queue absorbs the extra result and the block sustains one byte per cycle;
// input stalls only when the sink holds off and the queue has fewer than two
// free entries. The item with in_last always yields a result with out_last set
// (a bare marker with byte_valid low when there is no byte), after which the
// parser is back in its reset state.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder
    import cesd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_out_last
);

    logic       room;
    logic       consume;
    logic [7:0] cur_byte;
    logic       cur_last;
    t_dec_out   dec;

    cesd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_byte    (i_in_byte),
        .i_last    (i_in_last),
        .i_room    (room),
        .o_consume (consume),
        .o_byte    (cur_byte),
        .o_last    (cur_last)
    );

    cesd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_byte    (cur_byte),
        .i_last    (cur_last),
        .o_dec     (dec)
    );

    cesd_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (dec),
        .o_room       (room),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte       (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_out_last)
    );

endmodule

// ===== bench/c_escape_sequence_decoder_test.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_test
// Self-checking bench for the C escape sequence decoder. Source strings are
// sent one byte per transaction; an in-bench model of the unescaper predicts
// the decoded bytes, which are compared field by field as they come out.
// Directed strings cover the escape kinds and end cases, then random strings
// built from escape tokens run with random idling on both sides and without.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c_escape_sequence_decoder_test;
    import cesd_pkg::*;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    DRAIN_CYCLES = 10;
    localparam string SIMPLE_ESC = "abfnrtv\\?'\"";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string BAD_ESC    = "qz89eQ%(~ ";

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_in_last    = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_out_last;

    // decoder model state
    t_mode      mode_r;
    logic [7:0] pend_r;
    logic [1:0] ndig_r;
    logic       halt_r;

    t_result    step_out[$];
    t_result    decoded_q[$];
    logic [7:0] src_q[$];

    bit         idle_on;
    int         stall_left;
    int         cycle_cnt;
    int         mismatch_cnt;

    c_escape_sequence_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic void clear_decoder();
        mode_r = MODE_NORMAL;
        pend_r = 8'h00;
        ndig_r = 2'd0;
        halt_r = 1'b0;
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic v);
        t_result r;
        r.data       = b;
        r.byte_valid = v;
        r.last       = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void add_src(input logic [7:0] b);
        src_q.insert(src_q.size(), b);
    endfunction

    function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] nib);
        nib = 4'd0;
        if (b >= "0" && b <= "9") begin
            nib = 4'(b - "0");
            return 1'b1;
        end
        if (b >= "a" && b <= "f") begin
            nib = 4'(b - "a" + 8'd10);
            return 1'b1;
        end
        if (b >= "A" && b <= "F") begin
            nib = 4'(b - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == CH_NUL) begin
            halt_r = 1'b1;
            mode_r = MODE_NORMAL;
        end else if (b == CH_BACKSLASH) begin
            mode_r = MODE_ESC;
        end else begin
            put_byte(b, 1'b1);
        end
    endfunction

    function automatic void take_escape(input logic [7:0] b);
        mode_r = MODE_NORMAL;
        if (b == CH_NUL) begin
            halt_r = 1'b1;
        end else if (b >= "0" && b <= "7") begin
            pend_r = {5'd0, b[2:0]};
            ndig_r = 2'd1;
            mode_r = MODE_OCT;
        end else begin
            case (b)
                "a": put_byte(8'h07, 1'b1);
                "b": put_byte(8'h08, 1'b1);
                "f": put_byte(8'h0c, 1'b1);
                "n": put_byte(8'h0a, 1'b1);
                "r": put_byte(8'h0d, 1'b1);
                "t": put_byte(8'h09, 1'b1);
                "v": put_byte(8'h0b, 1'b1);
                CH_BACKSLASH, "?", "'", "\"": put_byte(b, 1'b1);
                "x", "X": mode_r = MODE_HEX;
                default: ;  // unknown escape: both bytes vanish
            endcase
        end
    endfunction

    // one source byte in, expected results appended to decoded_q
    function automatic void unescape_step(input logic [7:0] b, input logic last);
        logic [3:0] nib;
        if (!halt_r) begin
            case (mode_r)
                MODE_ESC: take_escape(b);
                MODE_OCT: begin
                    if (b >= "0" && b <= "7") begin
                        pend_r = {pend_r[4:0], b[2:0]};
                        ndig_r = ndig_r + 2'd1;
                        if (ndig_r == 2'd3) begin
                            put_byte(pend_r, 1'b1);
                            mode_r = MODE_NORMAL;
                            ndig_r = 2'd0;
                        end
                    end else begin
                        put_byte(pend_r, 1'b1);
                        mode_r = MODE_NORMAL;
                        ndig_r = 2'd0;
                        take_plain(b);
                    end
                end
                MODE_HEX: begin
                    if (hex_nibble(b, nib)) begin
                        pend_r = {4'd0, nib};
                        mode_r = MODE_HEX1;
                    end else begin
                        mode_r = MODE_NORMAL;
                        take_plain(b);
                    end
                end
                MODE_HEX1: begin
                    mode_r = MODE_NORMAL;
                    if (hex_nibble(b, nib)) begin
                        put_byte({pend_r[3:0], nib}, 1'b1);
                    end else begin
                        put_byte(pend_r, 1'b1);
                        take_plain(b);
                    end
                end
                default: begin
                    mode_r = MODE_NORMAL;
                    take_plain(b);
                end
            endcase
        end
        if (last) begin
            if (!halt_r && (mode_r == MODE_OCT || mode_r == MODE_HEX1))
                put_byte(pend_r, 1'b1);
            if (step_out.size() == 0)
                put_byte(CH_NUL, 1'b0);
            step_out[step_out.size() - 1].last = 1'b1;
            clear_decoder();
        end
        foreach (step_out[i])
            decoded_q.insert(decoded_q.size(), step_out[i]);
        step_out.delete();
    endfunction

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        unescape_step(b, last);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // random source string, mostly well-formed escape tokens
    function automatic void build_string();
        int         kind;
        logic [7:0] b;
        src_q.delete();
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_BACKSLASH) b = "/";
                add_src(b);
            end else if (kind < 45) begin
                add_src(CH_BACKSLASH);
                add_src(SIMPLE_ESC[$urandom_range(0, SIMPLE_ESC.len() - 1)]);
            end else if (kind < 60) begin
                add_src(CH_BACKSLASH);
                repeat ($urandom_range(1, 3))
                    add_src(8'(8'h30 + $urandom_range(0, 7)));
            end else if (kind < 73) begin
                add_src(CH_BACKSLASH);
                add_src($urandom_range(0, 1) ? "x" : "X");
                repeat ($urandom_range(1, 2))
                    add_src(HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)]);
            end else if (kind < 78) begin
                add_src(CH_BACKSLASH);
                add_src(BAD_ESC[$urandom_range(0, BAD_ESC.len() - 1)]);
            end else if (kind < 82) begin
                // hex intro with no digit; a leading hex digit of the next token becomes its digit
                add_src(CH_BACKSLASH);
                add_src("x");
            end else if (kind < 86) begin
                add_src(CH_NUL);
            end else if (kind < 89) begin
                add_src(CH_BACKSLASH);
                add_src(CH_NUL);
            end else begin
                add_src(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 19) == 0)
            add_src(CH_BACKSLASH);
    endfunction

    task automatic send_random_strings(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            build_string();
            foreach (src_q[i])
                send_byte(src_q[i], i == src_q.size() - 1);
            sent += src_q.size();
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_simple_escapes();
        send_byte(8'hff, 1'b0);
        // newline, question mark, unknown escape, hex value flushed by end
        send_text("\\n\\?\\q\\X4", 1'b1);
    endtask

    task automatic test_octal();
        // three digits wrap to 8 bits, a letter closes a one-digit value
        send_text("\\777\\1z", 1'b0);
        // value closed by a zero byte, then halted until the end marker
        send_text("\\1", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte("a", 1'b1);
    endtask

    task automatic test_termination();
        send_byte(CH_BACKSLASH, 1'b1);
        // hex intro without digit, then hex intro at end of string
        send_text("\\xg\\x", 1'b1);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_random_streams();
        idle_on = 1'b1;
        send_random_strings(800);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        send_random_strings(150);
    endtask

    // ------------------------------------------------------------------------
    // sink side: ready pattern and result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("c_escape_sequence_decoder: mismatch");
            $finish;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result byte=%h valid=%b last=%b",
                             $time, o_out_byte, o_byte_valid, o_out_last);
                    mismatch_cnt++;
                end else begin
                    exp_r = decoded_q.pop_front();
                    if (o_out_byte !== exp_r.data) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp_r.data, o_out_byte);
                        mismatch_cnt++;
                    end
                    if (o_byte_valid !== exp_r.byte_valid) begin
                        $display("%0t: byte_valid expected %b actual %b",
                                 $time, exp_r.byte_valid, o_byte_valid);
                        mismatch_cnt++;
                    end
                    if (o_out_last !== exp_r.last) begin
                        $display("%0t: out_last expected %b actual %b",
                                 $time, exp_r.last, o_out_last);
                        mismatch_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        idle_on      = 1'b1;
        stall_left   = 0;
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        clear_decoder();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_simple_escapes();
        test_octal();
        test_termination();
        test_random_streams();
        test_back_to_back();

        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("c_escape_sequence_decoder: match");
        else
            $display("c_escape_sequence_decoder: mismatch");
        $finish;
    end

endmodule
